@@ design/tpsi_pkg.sv @@
// Package for the triangle pair overlap unit: widths, sequencer states,
// multiply-accumulate control word and the edge and axis source tables.
// No dependencies.
package tpsi_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int AXIS_W    = 2 * EDGE_W;
  localparam int MUL_W     = EDGE_W + 1;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 104;
  localparam int XF_W      = 43;
  localparam int HI_SHIFT  = EDGE_W;

  localparam logic signed [ACC_W-1:0] XF_LIM_HI = ACC_W'(64'sd1099511627776);
  localparam logic signed [ACC_W-1:0] XF_LIM_LO = -XF_LIM_HI;
  localparam logic signed [XF_W-1:0]  C_MAX     = XF_W'(64'sd2147483647);
  localparam logic signed [XF_W-1:0]  C_MIN     = -C_MAX - XF_W'(1);

  localparam logic       OP_ROW    = 1'b0;
  localparam logic       OP_VERTEX = 1'b1;
  localparam logic [1:0] SLOT_NONE = 2'd3;
  localparam logic [3:0] AX_LAST   = 4'd10;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_XF_MUL, ST_XF_WAIT, ST_XF_WB,
    ST_ED_NEG, ST_ED_POS, ST_ED_WAIT, ST_ED_WB,
    ST_CR_MUL1, ST_CR_MUL2, ST_CR_WAIT, ST_CR_WB,
    ST_AX_CHK,
    ST_PR_MUL, ST_PR_WAIT, ST_PR_CMP,
    ST_SEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic issue;
    logic clr;
    logic sub;
    logic shift;
  } mac_ctl_t;

  // Edge slots 0..3 feed the first cross operand, 4..7 the second.
  function automatic logic [2:0] edge_from(logic [2:0] e);
    logic [2:0] r;
    unique case (e)
      3'd0, 3'd1, 3'd4: r = 3'd0;
      3'd2:             r = 3'd1;
      3'd3, 3'd5, 3'd6: r = 3'd3;
      default:          r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] edge_to(logic [2:0] e);
    logic [2:0] r;
    unique case (e)
      3'd0:             r = 3'd1;
      3'd1, 3'd2, 3'd4: r = 3'd2;
      3'd3, 3'd5:       r = 3'd4;
      default:          r = 3'd5;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] axis_a(logic [3:0] ax);
    logic [1:0] r;
    unique case (ax)
      4'd1:                   r = 2'd3;
      4'd5, 4'd6, 4'd7:       r = 2'd1;
      4'd8, 4'd9, 4'd10:      r = 2'd2;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] axis_b(logic [3:0] ax);
    logic [1:0] r;
    unique case (ax)
      4'd0:                   r = 2'd0;
      4'd1, 4'd3, 4'd6, 4'd9: r = 2'd2;
      4'd4, 4'd7, 4'd10:      r = 2'd3;
      default:                r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] next3(logic [1:0] k);
    logic [1:0] r;
    unique case (k)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/tpsi_mac.sv @@
// Shared multiply-accumulate unit: one 34x34 signed multiplier with a
// registered product, then a wide accumulator. Depends on tpsi_pkg.
module tpsi_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  tpsi_pkg::mac_ctl_t                  ctl,
  input  logic signed [tpsi_pkg::MUL_W-1:0]   mul_a,
  input  logic signed [tpsi_pkg::MUL_W-1:0]   mul_b,
  output logic signed [tpsi_pkg::ACC_W-1:0]   acc
);
  import tpsi_pkg::*;

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 ctl_q;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  term_s;
  logic signed [ACC_W-1:0]  acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    acc  <= acc_next;
  end

  always_comb begin
    term   = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    term_s = ctl_q.shift ? (term <<< HI_SHIFT) : term;
    if (ctl_q.sub) term_s = -term_s;
    if (!ctl_q.issue) acc_next = acc;
    else if (ctl_q.clr) acc_next = term_s;
    else acc_next = acc + term_s;
  end

endmodule

@@ design/triangle_pair_sat_intersect_unit.sv @@
// Triangle pair overlap unit, top level: load sequencer, vertex transform,
// separating axis evaluation. Depends on tpsi_pkg and tpsi_mac.
//
// A word either loads one row of a triangle's local-to-world matrix, or one
// local vertex that is transformed to world space on arrival (saturated to
// Q16.16), and may ask for an overlap test after its load. All arithmetic
// runs through one shared 34x34 multiplier with a registered product and a
// 104-bit accumulator, so the block takes one word at a time. A vertex load
// adds three rows of three multiplies, each with a drain and a write back.
// An evaluation builds the eight stored edges, then per candidate axis
// forms the cross product and checks it for zero, and projects the six
// vertices and compares when the axis is nonzero; it stops at the first
// separating axis, then posts the result. The result sits in an output
// register; a new word is taken while it waits, but the next result holds
// until the previous one is taken.
// intersect_res is 1 when no separating axis exists.
module triangle_pair_sat_intersect_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 operation,
  input  logic                                 triangle_select,
  input  logic [1:0]                           slot,
  input  logic signed [tpsi_pkg::COORD_W-1:0]  value_a,
  input  logic signed [tpsi_pkg::COORD_W-1:0]  value_b,
  input  logic signed [tpsi_pkg::COORD_W-1:0]  value_c,
  input  logic signed [tpsi_pkg::COORD_W-1:0]  value_d,
  input  logic                                 evaluate,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 intersect_res
);
  import tpsi_pkg::*;

  // State storage; matrix and world stores are undefined until written.
  logic signed [COORD_W-1:0] mat    [2][3][4];
  logic signed [COORD_W-1:0] world  [6][3];
  logic signed [EDGE_W-1:0]  edge_a [4][3];
  logic signed [EDGE_W-1:0]  edge_b [4][3];
  logic signed [AXIS_W-1:0]  axis   [3];
  logic signed [ACC_W-1:0]   pmin, pmax, qmin, qmax;

  // Held word.
  logic                      tri_q;
  logic [1:0]                slot_q;
  logic                      eval_q;
  logic signed [COORD_W-1:0] loc [3];

  state_t     state, state_next;
  logic [1:0] cnt_r;
  logic [1:0] cnt_k;
  logic [2:0] cnt_e;
  logic [3:0] cnt_ax;
  logic [2:0] cnt_pv;
  logic [2:0] cnt_st;
  logic       result;

  logic                      accept;
  mac_ctl_t                  mac_ctl;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [ACC_W-1:0]   acc;

  logic [1:0]                mat_col;
  logic signed [COORD_W-1:0] mat_rd;
  logic [2:0]                w_vi;
  logic [1:0]                w_ci;
  logic signed [COORD_W-1:0] w_rd;
  logic [1:0]                ea_ci, eb_ci;
  logic signed [EDGE_W-1:0]  ea_rd, eb_rd;
  logic signed [AXIS_W-1:0]  ax_rd;
  logic [2:0]                ld_vi;

  logic signed [ACC_W-1:0]   xf_shift;
  logic signed [XF_W-1:0]    xf_clip;
  logic signed [XF_W-1:0]    xf_sum;
  logic signed [COORD_W-1:0] xf_out;

  logic axis_zero;
  logic separated;
  logic first_v;
  logic result_take;

  assign accept      = in_valid && in_ready;
  assign in_ready    = (state == ST_IDLE);
  assign result_take = !out_valid || out_ready;
  assign ld_vi       = tri_q ? (3'(slot_q) + 3'd3) : 3'(slot_q);

  tpsi_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .acc   (acc)
  );

  // Read ports: one address per store, chosen by the sequencer.
  always_comb begin
    mat_col = (state == ST_XF_WB) ? 2'd3 : cnt_k;
    mat_rd  = mat[tri_q][cnt_r][mat_col];

    priority case (state)
      ST_ED_NEG: w_vi = edge_from(cnt_e);
      ST_ED_POS: w_vi = edge_to(cnt_e);
      default:   w_vi = cnt_pv;
    endcase
    w_ci = (state == ST_PR_MUL) ? cnt_st[2:1] : cnt_k;
    w_rd = world[w_vi][w_ci];

    ea_ci = (state == ST_CR_MUL1) ? next3(cnt_k) : next3(next3(cnt_k));
    eb_ci = (state == ST_CR_MUL1) ? next3(next3(cnt_k)) : next3(cnt_k);
    ea_rd = edge_a[axis_a(cnt_ax)][ea_ci];
    eb_rd = edge_b[axis_b(cnt_ax)][eb_ci];
    ax_rd = axis[cnt_st[2:1]];
  end

  // Vertex transform finish: floor by the fraction bits, clip, translate,
  // saturate to the coordinate range.
  always_comb begin
    xf_shift = acc >>> FRAC_BITS;
    if (xf_shift > XF_LIM_HI) xf_clip = XF_W'(XF_LIM_HI);
    else if (xf_shift < XF_LIM_LO) xf_clip = XF_W'(XF_LIM_LO);
    else xf_clip = xf_shift[XF_W-1:0];
    xf_sum = xf_clip + {{(XF_W-COORD_W){mat_rd[COORD_W-1]}}, mat_rd};
    if (xf_sum > C_MAX) xf_out = COORD_W'(C_MAX);
    else if (xf_sum < C_MIN) xf_out = COORD_W'(C_MIN);
    else xf_out = xf_sum[COORD_W-1:0];
  end

  assign axis_zero = (axis[0] == '0) && (axis[1] == '0) && (axis[2] == '0);
  assign separated = (pmax < qmin) || (qmax < pmin);
  assign first_v   = (cnt_pv == 3'd0) || (cnt_pv == 3'd3);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_VERTEX && slot != SLOT_NONE) state_next = ST_XF_MUL;
          else if (evaluate) state_next = ST_ED_NEG;
        end
      end
      ST_XF_MUL:  if (cnt_k == 2'd2) state_next = ST_XF_WAIT;
      ST_XF_WAIT: state_next = ST_XF_WB;
      ST_XF_WB: begin
        if (cnt_r != 2'd2) state_next = ST_XF_MUL;
        else if (eval_q) state_next = ST_ED_NEG;
        else state_next = ST_IDLE;
      end
      ST_ED_NEG:  state_next = ST_ED_POS;
      ST_ED_POS:  state_next = ST_ED_WAIT;
      ST_ED_WAIT: state_next = ST_ED_WB;
      ST_ED_WB: begin
        if (cnt_k == 2'd2 && cnt_e == 3'd7) state_next = ST_CR_MUL1;
        else state_next = ST_ED_NEG;
      end
      ST_CR_MUL1: state_next = ST_CR_MUL2;
      ST_CR_MUL2: state_next = ST_CR_WAIT;
      ST_CR_WAIT: state_next = ST_CR_WB;
      ST_CR_WB:   state_next = (cnt_k == 2'd2) ? ST_AX_CHK : ST_CR_MUL1;
      ST_AX_CHK: begin
        if (!axis_zero) state_next = ST_PR_MUL;
        else if (cnt_ax == AX_LAST) state_next = ST_DONE;
        else state_next = ST_CR_MUL1;
      end
      ST_PR_MUL:  if (cnt_st == 3'd5) state_next = ST_PR_WAIT;
      ST_PR_WAIT: state_next = ST_PR_CMP;
      ST_PR_CMP:  state_next = (cnt_pv == 3'd5) ? ST_SEP : ST_PR_MUL;
      ST_SEP: begin
        if (separated || cnt_ax == AX_LAST) state_next = ST_DONE;
        else state_next = ST_CR_MUL1;
      end
      ST_DONE:    if (result_take) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Multiplier operands and accumulate control.
  always_comb begin
    mac_ctl = '0;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state)
      ST_XF_MUL: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clr   = (cnt_k == 2'd0);
        mul_a = {{(MUL_W-COORD_W){mat_rd[COORD_W-1]}}, mat_rd};
        mul_b = {{(MUL_W-COORD_W){loc[cnt_k][COORD_W-1]}}, loc[cnt_k]};
      end
      ST_ED_NEG, ST_ED_POS: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clr   = (state == ST_ED_NEG);
        mul_a = {{(MUL_W-COORD_W){w_rd[COORD_W-1]}}, w_rd};
        mul_b = (state == ST_ED_NEG) ? {MUL_W{1'b1}} : MUL_W'(1);
      end
      ST_CR_MUL1, ST_CR_MUL2: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clr   = (state == ST_CR_MUL1);
        mac_ctl.sub   = (state == ST_CR_MUL2);
        mul_a = {ea_rd[EDGE_W-1], ea_rd};
        mul_b = {eb_rd[EDGE_W-1], eb_rd};
      end
      ST_PR_MUL: begin
        mac_ctl.issue = 1'b1;
        mac_ctl.clr   = (cnt_st == 3'd0);
        mac_ctl.shift = cnt_st[0];
        mul_a = cnt_st[0] ? {ax_rd[AXIS_W-1], ax_rd[AXIS_W-1:HI_SHIFT]}
                          : {1'b0, ax_rd[HI_SHIFT-1:0]};
        mul_b = {{(MUL_W-COORD_W){w_rd[COORD_W-1]}}, w_rd};
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt_r     <= '0;
      cnt_k     <= '0;
      cnt_e     <= '0;
      cnt_ax    <= '0;
      cnt_pv    <= '0;
      cnt_st    <= '0;
      result    <= 1'b0;
      out_valid <= 1'b0;
      intersect_res <= 1'b0;
      tri_q     <= 1'b0;
      slot_q    <= '0;
      eval_q    <= 1'b0;
    end else begin
      state <= state_next;
      // Post the result once the output register is free, else drop a taken word.
      if (state == ST_DONE && result_take) begin
        out_valid     <= 1'b1;
        intersect_res <= result;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt_r  <= '0;
          cnt_k  <= '0;
          cnt_e  <= '0;
          cnt_ax <= '0;
          cnt_pv <= '0;
          cnt_st <= '0;
          if (accept) begin
            tri_q  <= triangle_select;
            slot_q <= slot;
            eval_q <= evaluate;
          end
        end
        ST_XF_MUL: cnt_k <= (cnt_k == 2'd2) ? 2'd0 : cnt_k + 2'd1;
        ST_XF_WB:  cnt_r <= cnt_r + 2'd1;
        ST_ED_WB: begin
          if (cnt_k == 2'd2) begin
            cnt_k <= '0;
            cnt_e <= cnt_e + 3'd1;
          end else begin
            cnt_k <= cnt_k + 2'd1;
          end
        end
        ST_CR_WB:  cnt_k <= (cnt_k == 2'd2) ? 2'd0 : cnt_k + 2'd1;
        ST_AX_CHK: begin
          cnt_pv <= '0;
          cnt_st <= '0;
          if (axis_zero) begin
            if (cnt_ax == AX_LAST) result <= 1'b1;
            else cnt_ax <= cnt_ax + 4'd1;
          end
        end
        ST_PR_MUL: cnt_st <= (cnt_st == 3'd5) ? 3'd0 : cnt_st + 3'd1;
        ST_PR_CMP: cnt_pv <= cnt_pv + 3'd1;
        ST_SEP: begin
          if (separated) result <= 1'b0;
          else if (cnt_ax == AX_LAST) result <= 1'b1;
          else cnt_ax <= cnt_ax + 4'd1;
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // Data stores, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      loc[0] <= value_a;
      loc[1] <= value_b;
      loc[2] <= value_c;
      if (operation == OP_ROW && slot != SLOT_NONE) begin
        mat[triangle_select][slot][0] <= value_a;
        mat[triangle_select][slot][1] <= value_b;
        mat[triangle_select][slot][2] <= value_c;
        mat[triangle_select][slot][3] <= value_d;
      end
    end
    if (state == ST_XF_WB) world[ld_vi][cnt_r] <= xf_out;
    if (state == ST_ED_WB) begin
      if (!cnt_e[2]) edge_a[cnt_e[1:0]][cnt_k] <= acc[EDGE_W-1:0];
      else edge_b[cnt_e[1:0]][cnt_k] <= acc[EDGE_W-1:0];
    end
    if (state == ST_CR_WB) axis[cnt_k] <= acc[AXIS_W-1:0];
    if (state == ST_PR_CMP) begin
      // Track the projection interval of the triangle this vertex is in.
      if (!cnt_pv[2] && cnt_pv != 3'd3) begin
        if (first_v || acc < pmin) pmin <= acc;
        if (first_v || acc > pmax) pmax <= acc;
      end else begin
        if (first_v || acc < qmin) qmin <= acc;
        if (first_v || acc > qmax) qmax <= acc;
      end
    end
  end

endmodule
